@@ design/tfp_pkg.sv @@
// Shared types and constants for the tagged frame parser with CRC-8 check.
// No dependencies; imported by tfp_frame_store and the top level.
package tfp_pkg;

   // Content store depth; frames hold at most this many content bytes.
   localparam int BufferDepth = 64;
   localparam int AddrWidth   = (BufferDepth > 1) ? $clog2(BufferDepth) : 1;
   localparam int CountWidth  = $clog2(BufferDepth + 1);
   localparam int CharWidth   = 8;
   localparam int LenWidth    = 7;

   typedef logic [CharWidth-1:0]  char_type;
   typedef logic [CountWidth-1:0] count_type;
   typedef logic [AddrWidth-1:0]  addr_type;

   // Write port of the content store, driven by the parser.
   typedef struct packed {
      logic     we;
      addr_type addr;
      char_type data;
   } store_write_type;

   // Hand-over of an accepted frame from the parser to the result emitter.
   typedef struct packed {
      logic      start;
      count_type len;
      char_type  tag_first;
      char_type  tag_second;
   } frame_start_type;

endpackage

@@ design/tagged_frame_parser_crc8_unit.sv @@
// Top level of the tagged frame parser with CRC-8 check.
// Depends on tfp_pkg and tfp_frame_store.
//
// Takes one received character per request and hunts for a two-letter tag (A-Z, a-z,
// case-sensitive). An ordinary tag collects numeric content (0-9 + - .) up to ':' and is
// followed by two hex checksum digits; the frame is accepted when CRC-8 (polynomial 0xD5,
// MSB first, initial value 0) over both tag letters and the stored content equals the
// checksum. Tag IM opens a binary block of BUFFER_DEPTH-1 bytes; tag MS reads 4-digit hex
// lengths and opens a block when a length repeats the remembered one (clamped to
// BUFFER_DEPTH). A bad character or a failed checksum sends the parser back to tag hunting
// with that same character. Timing: the parser takes one character per cycle unless
// stalled, keeping the CRC running as content arrives. An accepted frame of n content
// bytes comes out as n results (one result with byte_valid low for an empty frame); the
// read-back goes through the single read port of the content store, whose read data is
// registered, and requests are stalled while the frame is being read back. The output
// register lets the next request in while the final result waits.
// The content store needs no clearing after reset: a frame only reads what it has written.
module tagged_frame_parser_crc8_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tfp_pkg::char_type req_in_char,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tfp_pkg::char_type rsp_tag_first,
   output tfp_pkg::char_type rsp_tag_second,
   output tfp_pkg::char_type rsp_data_byte,
   output logic              rsp_byte_valid,
   output logic              rsp_last_byte,
   output logic [6:0]        rsp_content_length
);
   import tfp_pkg::*;

   typedef enum logic [4:0] {
      PH_HUNT    = 5'b00001,
      PH_CONTENT = 5'b00010,
      PH_CHECK   = 5'b00100,
      PH_BLOCK   = 5'b01000,
      PH_LENGTH  = 5'b10000
   } phase_type;

   localparam char_type CrcPoly  = 8'hD5;
   localparam char_type ChNone   = 8'h00;
   localparam char_type ChZero   = 8'h30;
   localparam char_type ChNine   = 8'h39;
   localparam char_type ChPlus   = 8'h2B;
   localparam char_type ChMinus  = 8'h2D;
   localparam char_type ChDot    = 8'h2E;
   localparam char_type ChColon  = 8'h3A;
   localparam char_type ChUpA    = 8'h41;
   localparam char_type ChUpF    = 8'h46;
   localparam char_type ChUpZ    = 8'h5A;
   localparam char_type ChLowA   = 8'h61;
   localparam char_type ChLowF   = 8'h66;
   localparam char_type ChLowZ   = 8'h7A;
   localparam char_type ChI      = 8'h49;
   localparam char_type ChM      = 8'h4D;
   localparam char_type ChS      = 8'h53;
   localparam int       LenDigits = 4;

   // One byte of CRC-8, MSB first.
   function automatic char_type crc8_step(input char_type crc, input char_type b);
      char_type v;
      v = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         v = v[7] ? ({v[6:0], 1'b0} ^ CrcPoly) : {v[6:0], 1'b0};
      end
      return v;
   endfunction

   // {valid, value} of one hex character.
   function automatic logic [4:0] hex_digit(input char_type c);
      logic [4:0] r;
      r = '0;
      if (c >= ChZero && c <= ChNine) begin
         r = {1'b1, 4'(c - ChZero)};
      end else if (c >= ChLowA && c <= ChLowF) begin
         r = {1'b1, 4'(c - ChLowA + 8'd10)};
      end else if (c >= ChUpA && c <= ChUpF) begin
         r = {1'b1, 4'(c - ChUpA + 8'd10)};
      end
      return r;
   endfunction

   // Leading hex digits of up to four characters, first in d[0]: {ok, value}.
   function automatic logic [16:0] parse_hex(input logic [3:0][7:0] d);
      logic [15:0] v;
      logic        run;
      logic        ok;
      logic [4:0]  h;
      v   = '0;
      run = 1'b1;
      ok  = 1'b0;
      for (int i = 0; i < 4; i++) begin
         h = hex_digit(d[i]);
         if (run && h[4]) begin
            v  = {v[11:0], h[3:0]};
            ok = 1'b1;
         end else begin
            run = 1'b0;
         end
      end
      return {ok, v};
   endfunction

   phase_type   phase_ff, phase_in;
   char_type    tag0_ff, tag0_in;
   char_type    tag1_ff, tag1_in;
   logic        tag_count_ff, tag_count_in;
   count_type   count_ff, count_in;
   logic [1:0]  digit_count_ff, digit_count_in;
   char_type    digit_chars_ff [3];
   char_type    digit_chars_in [3];
   count_type   block_target_ff, block_target_in;
   logic [15:0] remembered_ff, remembered_in;
   char_type    crc_ff, crc_in;

   logic            accept;
   logic            is_alpha;
   logic            is_numeric;
   logic            do_hunt;
   logic [16:0]     hex_check;
   logic [16:0]     hex_length;
   logic            store_busy;
   store_write_type store_wr;
   frame_start_type frame_start;

   assign accept     = req_valid && !req_stall;
   assign is_alpha   = (req_in_char >= ChUpA && req_in_char <= ChUpZ) ||
                       (req_in_char >= ChLowA && req_in_char <= ChLowZ);
   assign is_numeric = (req_in_char >= ChZero && req_in_char <= ChNine) ||
                       req_in_char == ChPlus || req_in_char == ChMinus ||
                       req_in_char == ChDot;

   // Checksum digits: the first is held, the second is the current character.
   assign hex_check  = parse_hex({ChNone, ChNone, req_in_char, digit_chars_ff[0]});
   // Length digits: three held, the fourth is the current character.
   assign hex_length = parse_hex({req_in_char, digit_chars_ff[2], digit_chars_ff[1],
                                  digit_chars_ff[0]});

   always_comb begin
      phase_in        = phase_ff;
      tag0_in         = tag0_ff;
      tag1_in         = tag1_ff;
      tag_count_in    = tag_count_ff;
      count_in        = count_ff;
      digit_count_in  = digit_count_ff;
      digit_chars_in  = digit_chars_ff;
      block_target_in = block_target_ff;
      remembered_in   = remembered_ff;
      crc_in          = crc_ff;
      do_hunt         = 1'b0;
      store_wr        = '0;
      frame_start     = '0;

      if (accept) begin
         unique case (phase_ff)
            PH_CONTENT: begin
               if (req_in_char == ChColon) begin
                  phase_in = PH_CHECK;
               end else if (is_numeric) begin
                  // Characters beyond the store depth are dropped silently.
                  if (count_ff < CountWidth'(BufferDepth)) begin
                     store_wr.we   = 1'b1;
                     store_wr.addr = count_ff[AddrWidth-1:0];
                     store_wr.data = req_in_char;
                     count_in      = count_ff + count_type'(1);
                     crc_in        = crc8_step(crc_ff, req_in_char);
                  end
               end else begin
                  // Drop the content and rehandle this character as tag hunting.
                  phase_in = PH_HUNT;
                  count_in = '0;
                  do_hunt  = 1'b1;
               end
            end
            PH_CHECK: begin
               if (digit_count_ff == '0) begin
                  digit_chars_in[0] = req_in_char;
                  digit_count_in    = 2'(1);
               end else begin
                  phase_in       = PH_HUNT;
                  digit_count_in = '0;
                  count_in       = '0;
                  if (hex_check[16] && hex_check[7:0] == crc_ff) begin
                     frame_start.start      = 1'b1;
                     frame_start.len        = count_ff;
                     frame_start.tag_first  = tag0_ff;
                     frame_start.tag_second = tag1_ff;
                  end else begin
                     do_hunt = 1'b1;
                  end
               end
            end
            PH_BLOCK: begin
               if (count_ff >= block_target_ff) begin
                  // Block full: consume this character and emit the frame.
                  frame_start.start      = 1'b1;
                  frame_start.len        = count_ff;
                  frame_start.tag_first  = tag0_ff;
                  frame_start.tag_second = tag1_ff;
                  phase_in               = PH_HUNT;
                  digit_count_in         = '0;
                  count_in               = '0;
               end else begin
                  store_wr.we   = 1'b1;
                  store_wr.addr = count_ff[AddrWidth-1:0];
                  store_wr.data = req_in_char;
                  count_in      = count_ff + count_type'(1);
               end
            end
            PH_LENGTH: begin
               if (digit_count_ff == 2'(LenDigits - 1)) begin
                  digit_count_in = '0;
                  if (!hex_length[16]) begin
                     phase_in = PH_HUNT;
                  end else if (remembered_ff != '0) begin
                     if (remembered_ff == hex_length[15:0]) begin
                        block_target_in = (hex_length[15:0] > 16'(BufferDepth)) ?
                                          CountWidth'(BufferDepth) :
                                          hex_length[CountWidth-1:0];
                        phase_in        = PH_BLOCK;
                     end else begin
                        phase_in = PH_HUNT;
                     end
                  end else begin
                     // Nothing remembered yet: remember it and keep reading lengths.
                     remembered_in = hex_length[15:0];
                  end
               end else begin
                  digit_chars_in[digit_count_ff] = req_in_char;
                  digit_count_in                 = digit_count_ff + 2'(1);
               end
            end
            default: begin
               // Tag hunting, and any unused phase code.
               phase_in = PH_HUNT;
               do_hunt  = 1'b1;
            end
         endcase

         if (do_hunt) begin
            if (!is_alpha) begin
               tag_count_in = 1'b0;
            end else if (!tag_count_ff) begin
               tag0_in      = req_in_char;
               tag_count_in = 1'b1;
               crc_in       = crc8_step('0, req_in_char);
            end else begin
               tag1_in         = req_in_char;
               tag_count_in    = 1'b0;
               crc_in          = crc8_step(crc_ff, req_in_char);
               block_target_in = CountWidth'(BufferDepth - 1);
               priority if (tag0_ff == ChI && req_in_char == ChM) begin
                  phase_in = PH_BLOCK;
               end else if (tag0_ff == ChM && req_in_char == ChS) begin
                  phase_in = PH_LENGTH;
               end else begin
                  phase_in = PH_CONTENT;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HUNT;
         tag_count_ff    <= 1'b0;
         count_ff        <= '0;
         digit_count_ff  <= '0;
         block_target_ff <= '0;
         remembered_ff   <= '0;
         tag0_ff         <= '0;
         tag1_ff         <= '0;
      end else begin
         phase_ff        <= phase_in;
         tag_count_ff    <= tag_count_in;
         count_ff        <= count_in;
         digit_count_ff  <= digit_count_in;
         block_target_ff <= block_target_in;
         remembered_ff   <= remembered_in;
         tag0_ff         <= tag0_in;
         tag1_ff         <= tag1_in;
      end
   end

   always_ff @(posedge clock) begin
      digit_chars_ff <= digit_chars_in;
      crc_ff         <= crc_in;
   end

   // Hold off requests while a frame is being read back.
   assign req_stall = store_busy;

   tfp_frame_store u_store (
      .clock              (clock),
      .reset              (reset),
      .wr                 (store_wr),
      .frame              (frame_start),
      .busy               (store_busy),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_tag_first      (rsp_tag_first),
      .rsp_tag_second     (rsp_tag_second),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_last_byte      (rsp_last_byte),
      .rsp_content_length (rsp_content_length)
   );

   // A handed-over frame stalls the very next request.
   a_start_stalls: assert property (@(posedge clock) disable iff (reset)
      frame_start.start |=> req_stall)
      else $error("request not stalled after frame hand-over");

   // The content store is only written by an accepted request.
   a_write_on_accept: assert property (@(posedge clock) disable iff (reset)
      store_wr.we |-> accept)
      else $error("store write without an accepted request");

   // Digit counting only happens while reading a checksum or a length.
   a_digits_phase: assert property (@(posedge clock) disable iff (reset)
      digit_count_ff != '0 |-> phase_ff == PH_CHECK || phase_ff == PH_LENGTH)
      else $error("digit count left over outside digit phases");

endmodule

@@ design/tfp_frame_store.sv @@
// Content store memory of the frame parser and the result emitter that reads it back.
// Depends on tfp_pkg.
module tfp_frame_store (
   input  logic                     clock,
   input  logic                     reset,
   input  tfp_pkg::store_write_type wr,
   input  tfp_pkg::frame_start_type frame,
   output logic                     busy,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output tfp_pkg::char_type        rsp_tag_first,
   output tfp_pkg::char_type        rsp_tag_second,
   output tfp_pkg::char_type        rsp_data_byte,
   output logic                     rsp_byte_valid,
   output logic                     rsp_last_byte,
   output logic [6:0]               rsp_content_length
);
   import tfp_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_LOAD = 2'b10
   } emit_state_type;

   char_type       mem [BufferDepth];
   char_type       rdata_ff;
   logic           rd_en;
   addr_type       rd_addr;

   emit_state_type state_ff, state_in;
   count_type      len_ff, len_in;
   count_type      issued_ff, issued_in;
   char_type       tag0_ff, tag0_in;
   char_type       tag1_ff, tag1_in;

   logic           rsp_valid_ff, rsp_valid_in;
   char_type       rsp_tag_first_ff, rsp_tag_first_in;
   char_type       rsp_tag_second_ff, rsp_tag_second_in;
   char_type       rsp_data_byte_ff, rsp_data_byte_in;
   logic           rsp_byte_valid_ff, rsp_byte_valid_in;
   logic           rsp_last_byte_ff, rsp_last_byte_in;
   logic [LenWidth-1:0] rsp_content_length_ff, rsp_content_length_in;

   logic           out_free;
   logic           run_last;

   always_comb begin
      state_in              = state_ff;
      len_in                = len_ff;
      issued_in             = issued_ff;
      tag0_in               = tag0_ff;
      tag1_in               = tag1_ff;
      rd_en                 = 1'b0;
      rd_addr               = '0;
      rsp_valid_in          = rsp_valid_ff;
      rsp_tag_first_in      = rsp_tag_first_ff;
      rsp_tag_second_in     = rsp_tag_second_ff;
      rsp_data_byte_in      = rsp_data_byte_ff;
      rsp_byte_valid_in     = rsp_byte_valid_ff;
      rsp_last_byte_in      = rsp_last_byte_ff;
      rsp_content_length_in = rsp_content_length_ff;

      out_free = !rsp_valid_ff || !rsp_stall;
      run_last = (issued_ff == len_ff);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (frame.start) begin
               len_in    = frame.len;
               tag0_in   = frame.tag_first;
               tag1_in   = frame.tag_second;
               issued_in = '0;
               state_in  = ST_LOAD;
               if (frame.len != '0) begin
                  rd_en     = 1'b1;
                  rd_addr   = '0;
                  issued_in = count_type'(1);
               end
            end
         end
         ST_LOAD: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_tag_first_in      = tag0_ff;
               rsp_tag_second_in     = tag1_ff;
               rsp_data_byte_in      = (len_ff == '0) ? '0 : rdata_ff;
               rsp_byte_valid_in     = (len_ff != '0);
               rsp_last_byte_in      = run_last;
               rsp_content_length_in = LenWidth'(len_ff);
               if (run_last) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_en     = 1'b1;
                  rd_addr   = issued_ff[AddrWidth-1:0];
                  issued_in = issued_ff + count_type'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff                <= len_in;
      issued_ff             <= issued_in;
      tag0_ff               <= tag0_in;
      tag1_ff               <= tag1_in;
      rsp_tag_first_ff      <= rsp_tag_first_in;
      rsp_tag_second_ff     <= rsp_tag_second_in;
      rsp_data_byte_ff      <= rsp_data_byte_in;
      rsp_byte_valid_ff     <= rsp_byte_valid_in;
      rsp_last_byte_ff      <= rsp_last_byte_in;
      rsp_content_length_ff <= rsp_content_length_in;
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_tag_first      = rsp_tag_first_ff;
   assign rsp_tag_second     = rsp_tag_second_ff;
   assign rsp_data_byte      = rsp_data_byte_ff;
   assign rsp_byte_valid     = rsp_byte_valid_ff;
   assign rsp_last_byte      = rsp_last_byte_ff;
   assign rsp_content_length = rsp_content_length_ff;

   // The store is never written while a run is being read back.
   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !wr.we)
      else $error("content store written during read-back");

   // A new frame is only handed over while the emitter is idle.
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      frame.start |-> state_ff == ST_IDLE)
      else $error("frame start while emitter busy");

   // Reads never run past the frame length.
   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD |-> issued_ff <= len_ff)
      else $error("read index beyond frame length");

   // An empty-frame result always closes its run.
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_byte_valid_ff |-> rsp_last_byte_ff)
      else $error("empty result not marked last");

endmodule

@@ tb/tfp_frame_checker.sv @@
// Checker for the tagged frame parser: watches both channels, predicts the result run of
// every accepted frame and compares it byte by byte. Depends on tfp_pkg only.
`timescale 1ns / 1ps
module tfp_frame_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  tfp_pkg::char_type req_in_char,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  tfp_pkg::char_type rsp_tag_first,
   input  tfp_pkg::char_type rsp_tag_second,
   input  tfp_pkg::char_type rsp_data_byte,
   input  logic              rsp_byte_valid,
   input  logic              rsp_last_byte,
   input  logic [6:0]        rsp_content_length,
   output int                failures,
   output int                pending
);
   import tfp_pkg::*;

   typedef enum logic [2:0] {
      ScanTag,
      ReadContent,
      ReadChecksum,
      ReadBlock,
      ReadLength
   } parse_phase_type;

   typedef struct packed {
      char_type   tag_first;
      char_type   tag_second;
      char_type   data_byte;
      logic       byte_valid;
      logic       last_byte;
      logic [6:0] content_length;
   } frame_byte_type;

   frame_byte_type  expected_bytes[$];
   parse_phase_type phase;
   char_type        tag_letters[2];
   logic            tag_half;
   char_type        content[BufferDepth];
   int              content_count;
   int              digit_count;
   char_type        digit_chars[4];
   int              block_target;
   logic [15:0]     remembered_length;

   function automatic logic [7:0] crc8_next(input logic [7:0] crc, input char_type b);
      logic [7:0] v;
      v = crc ^ b;
      repeat (8) v = v[7] ? ({v[6:0], 1'b0} ^ 8'hD5) : {v[6:0], 1'b0};
      return v;
   endfunction

   // Value of the leading hex digits among the first count digit characters.
   function automatic bit leading_hex(input int count, output logic [15:0] value);
      int         got;
      bit         stopped;
      bit         is_hex;
      logic [3:0] nibble;
      value   = '0;
      got     = 0;
      stopped = 1'b0;
      for (int i = 0; i < count; i++) begin
         is_hex = 1'b1;
         nibble = '0;
         if (digit_chars[i] >= "0" && digit_chars[i] <= "9") begin
            nibble = 4'(digit_chars[i] - "0");
         end else if (digit_chars[i] >= "a" && digit_chars[i] <= "f") begin
            nibble = 4'(digit_chars[i] - "a" + 8'd10);
         end else if (digit_chars[i] >= "A" && digit_chars[i] <= "F") begin
            nibble = 4'(digit_chars[i] - "A" + 8'd10);
         end else begin
            is_hex = 1'b0;
         end
         if (!is_hex) stopped = 1'b1;
         if (!stopped) begin
            value = {value[11:0], nibble};
            got++;
         end
      end
      return got > 0;
   endfunction

   function automatic void scan_tag(input char_type c);
      if (!((c >= "A" && c <= "Z") || (c >= "a" && c <= "z"))) begin
         tag_half = 1'b0;
         return;
      end
      tag_letters[tag_half] = c;
      if (!tag_half) begin
         tag_half = 1'b1;
         return;
      end
      tag_half     = 1'b0;
      block_target = BufferDepth - 1;
      if (tag_letters[0] == "I" && tag_letters[1] == "M") phase = ReadBlock;
      else if (tag_letters[0] == "M" && tag_letters[1] == "S") phase = ReadLength;
      else phase = ReadContent;
   endfunction

   function automatic void emit_frame();
      frame_byte_type r;
      r.tag_first  = tag_letters[0];
      r.tag_second = tag_letters[1];
      if (content_count == 0) begin
         r.data_byte      = '0;
         r.byte_valid     = 1'b0;
         r.last_byte      = 1'b1;
         r.content_length = '0;
         expected_bytes.push_back(r);
      end else begin
         for (int k = 0; k < content_count; k++) begin
            r.data_byte      = content[k];
            r.byte_valid     = 1'b1;
            r.last_byte      = (k == content_count - 1);
            r.content_length = 7'(content_count);
            expected_bytes.push_back(r);
         end
      end
   endfunction

   function automatic void predict_request(input char_type c);
      logic [15:0] value;
      logic [7:0]  crc;
      case (phase)
         ReadContent: begin
            if (c == ":") begin
               phase = ReadChecksum;
            end else if ((c >= "0" && c <= "9") || c == "+" || c == "-" || c == ".") begin
               if (content_count < BufferDepth) begin
                  content[content_count] = c;
                  content_count++;
               end
            end else begin
               phase         = ScanTag;
               content_count = 0;
               scan_tag(c);
            end
         end
         ReadChecksum: begin
            if (digit_count == 0) begin
               digit_chars[0] = c;
               digit_count    = 1;
            end else begin
               digit_chars[1] = c;
               phase          = ScanTag;
               digit_count    = 0;
               crc = crc8_next(8'h00, tag_letters[0]);
               crc = crc8_next(crc, tag_letters[1]);
               for (int i = 0; i < content_count; i++) crc = crc8_next(crc, content[i]);
               if (leading_hex(2, value) && value == {8'h00, crc}) begin
                  emit_frame();
                  content_count = 0;
               end else begin
                  content_count = 0;
                  scan_tag(c);
               end
            end
         end
         ReadBlock: begin
            if (content_count >= block_target) begin
               emit_frame();
               phase         = ScanTag;
               digit_count   = 0;
               content_count = 0;
            end else begin
               content[content_count] = c;
               content_count++;
            end
         end
         ReadLength: begin
            digit_chars[digit_count % 4] = c;
            digit_count++;
            if (digit_count >= 4) begin
               digit_count = 0;
               if (!leading_hex(4, value)) begin
                  phase = ScanTag;
               end else if (remembered_length == 16'h0000) begin
                  remembered_length = value;
               end else if (remembered_length == value) begin
                  block_target = (value > BufferDepth) ? BufferDepth : int'(value);
                  phase        = ReadBlock;
               end else begin
                  phase = ScanTag;
               end
            end
         end
         default: begin
            phase = ScanTag;
            scan_tag(c);
         end
      endcase
   endfunction

   function automatic void compare_field(input string name, input logic [7:0] want,
                                         input logic [7:0] got);
      if (got !== want) begin
         $error("rsp_%s mismatch: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      frame_byte_type oldest;
      if (reset) begin
         phase             = ScanTag;
         tag_letters       = '{default: '0};
         tag_half          = 1'b0;
         content_count     = 0;
         digit_count       = 0;
         digit_chars       = '{default: '0};
         block_target      = 0;
         remembered_length = '0;
         failures          = 0;
         expected_bytes.delete();
      end else begin
         if (req_valid && !req_stall) predict_request(req_in_char);
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               $error("result with no frame byte outstanding: data_byte %0h", rsp_data_byte);
               failures++;
            end else begin
               oldest = expected_bytes.pop_front();
               compare_field("tag_first", oldest.tag_first, rsp_tag_first);
               compare_field("tag_second", oldest.tag_second, rsp_tag_second);
               compare_field("data_byte", oldest.data_byte, rsp_data_byte);
               compare_field("byte_valid", oldest.byte_valid, rsp_byte_valid);
               compare_field("last_byte", oldest.last_byte, rsp_last_byte);
               compare_field("content_length", oldest.content_length, rsp_content_length);
            end
         end
      end
      pending = expected_bytes.size();
   end

endmodule

@@ tb/testbench.sv @@
// Top of the testbench for tagged_frame_parser_crc8_unit: clock, reset, character
// stimulus and the verdict. Depends on tfp_pkg and tfp_frame_checker.
`timescale 1ns / 1ps
module testbench;
   import tfp_pkg::*;

   // Generous ceiling on the whole run, even with heavy stalling.
   localparam int CycleLimit   = 300000;
   // Settling time after the last frame byte; the longest result run is BufferDepth results.
   localparam int DrainCycles  = 200;
   // Characters sent in all, directed part included.
   localparam int TotalChars   = 470;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   char_type   req_in_char = '0;
   logic       rsp_stall   = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   char_type   rsp_tag_first;
   char_type   rsp_tag_second;
   char_type   rsp_data_byte;
   logic       rsp_byte_valid;
   logic       rsp_last_byte;
   logic [6:0] rsp_content_length;
   int         failures;
   int         pending;

   int          cycle_count  = 0;
   int          chars_sent   = 0;
   int          req_idle_pct = 19;
   int          rsp_idle_pct = 58;
   logic [15:0] ms_length;
   char_type    outgoing_chars[$];

   tagged_frame_parser_crc8_unit u_top (.*);

   tfp_frame_checker u_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hold the result side off at random; the rate follows the current idling phase.
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   // Drop the run if it hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Present one request, idling beforehand at random, and hold it until it is taken.
   task automatic send_char(input char_type c);
      // Swap the idling rates after a third of the run, then stop idling for the last third.
      if (chars_sent >= 2 * TotalChars / 3) begin
         req_idle_pct = 0;
         rsp_idle_pct = 0;
      end else if (chars_sent >= TotalChars / 3) begin
         req_idle_pct = 58;
         rsp_idle_pct = 19;
      end
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_char <= c;
      do @(posedge clock); while (req_stall);
      chars_sent++;
   endtask

   task automatic send_outgoing();
      while (outgoing_chars.size() != 0) send_char(outgoing_chars.pop_front());
   endtask

   function automatic void add_char(input char_type c);
      outgoing_chars.push_back(c);
   endfunction

   function automatic void add_text(input string t);
      for (int i = 0; i < t.len(); i++) add_char(t[i]);
   endfunction

   function automatic char_type hex_char(input logic [3:0] nibble, input bit upper);
      if (nibble < 4'd10) return char_type'("0" + nibble);
      return char_type'((upper ? "A" : "a") + nibble - 8'd10);
   endfunction

   function automatic void add_hex4(input logic [15:0] value, input bit upper);
      for (int i = 3; i >= 0; i--) add_char(hex_char(value[4*i +: 4], upper));
   endfunction

   function automatic char_type numeric_char();
      string symbols;
      symbols = "0123456789+-.";
      return symbols[$urandom_range(12)];
   endfunction

   function automatic char_type random_letter();
      if ($urandom_range(1)) return char_type'("A" + $urandom_range(25));
      return char_type'("a" + $urandom_range(25));
   endfunction

   // A separator clears any half-collected tag left behind by earlier noise.
   function automatic void add_separator();
      string seps;
      seps = ",; *$\n";
      add_char(seps[$urandom_range(seps.len() - 1)]);
   endfunction

   // Queue separator and tag; return where the checksummed text starts.
   function automatic int add_tag(input char_type first, input char_type second);
      int start;
      add_separator();
      start = outgoing_chars.size();
      add_char(first);
      add_char(second);
      return start;
   endfunction

   // Any tag but the two block tags, so that numeric content follows.
   function automatic int add_random_tag();
      char_type first;
      char_type second;
      do begin
         first  = random_letter();
         second = random_letter();
      end while ((first == "I" && second == "M") || (first == "M" && second == "S"));
      return add_tag(first, second);
   endfunction

   // Close a numeric frame: ':' and the CRC-8 over tag and the stored part of the content.
   function automatic void add_checksum(input int start, input bit corrupt);
      logic [7:0] crc;
      int         stored;
      bit         upper;
      stored = outgoing_chars.size() - start - 2;
      if (stored > BufferDepth) stored = BufferDepth;
      crc = 8'h00;
      for (int i = start; i < start + 2 + stored; i++) begin
         crc = crc ^ outgoing_chars[i];
         repeat (8) crc = crc[7] ? ({crc[6:0], 1'b0} ^ 8'hD5) : {crc[6:0], 1'b0};
      end
      if (corrupt) crc = crc ^ 8'(1 << $urandom_range(7));
      upper = $urandom_range(1);
      add_char(":");
      add_char(hex_char(crc[7:4], upper));
      add_char(hex_char(crc[3:0], upper));
   endfunction

   // Binary block body plus the character that closes it.
   function automatic void add_block_bytes(input int count);
      repeat (count + 1) add_char(char_type'($urandom_range(255)));
   endfunction

   // Remembered length written without leading zeros and padded with non-hex characters.
   function automatic void add_short_length();
      string junk;
      junk = "gz:/ ~";
      add_char(hex_char(ms_length[7:4], $urandom_range(1)));
      add_char(hex_char(ms_length[3:0], $urandom_range(1)));
      add_char(junk[$urandom_range(junk.len() - 1)]);
      add_char(junk[$urandom_range(junk.len() - 1)]);
   endfunction

   initial begin
      int start;
      int pick;
      int count;
      logic [15:0] other_length;

      // Above the buffer depth, so every length-tagged block is clamped.
      ms_length = 16'($urandom_range(65, 255));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Length tag: zero while nothing is remembered, remember, then open a block on
      // the repeat.
      add_separator();
      add_text("MS0000");
      add_hex4(ms_length, 1'b1);
      add_hex4(ms_length, 1'b0);
      add_block_bytes(BufferDepth);
      // Empty frame, then every numeric symbol.
      start = add_tag("A", "z");
      add_checksum(start, 1'b0);
      start = add_tag("a", "Z");
      add_text("+-.0123456789");
      add_checksum(start, 1'b0);
      // Lower-case block tag is an ordinary tag.
      start = add_tag("i", "m");
      add_text("42");
      add_checksum(start, 1'b0);
      // Wrong checksum, non-hex first checksum digit, only one leading hex digit.
      start = add_tag("Q", "r");
      add_text("-7.5");
      add_checksum(start, 1'b1);
      void'(add_tag("T", "t"));
      add_text("1:g5");
      void'(add_tag("U", "u"));
      add_text("9:5g");
      // Bad content characters: a symbol, then a letter that starts a new tag.
      void'(add_tag("B", "c"));
      add_text("12#34");
      void'(add_tag("D", "e"));
      add_char("5");
      start = outgoing_chars.size();
      add_text("Xy7");
      add_checksum(start, 1'b0);
      // Non-letter between tag letters, and character extremes while hunting.
      add_text(" A5B ");
      add_char(8'h00);
      add_char(8'hFF);
      add_char(8'h80);
      add_char(8'h7F);
      // Content overflow past the buffer depth.
      start = add_random_tag();
      repeat (BufferDepth + 6) add_char(numeric_char());
      add_checksum(start, 1'b0);
      // Fixed-size binary block.
      add_separator();
      add_text("IM");
      add_block_bytes(BufferDepth - 1);
      // Length mismatch, unparsable length, short form of the remembered length.
      add_separator();
      add_text("MS");
      add_hex4(ms_length ^ 16'h0100, 1'b1);
      add_separator();
      add_text("MSz012");
      add_separator();
      add_text("MS");
      add_short_length();
      add_block_bytes(BufferDepth);
      send_outgoing();

      while (chars_sent < TotalChars) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            // Well-formed numeric frame, now and then too long or with a bad checksum.
            count = ($urandom_range(49) == 0) ? $urandom_range(60, 70) : $urandom_range(10);
            start = add_random_tag();
            repeat (count) add_char(numeric_char());
            add_checksum(start, $urandom_range(99) < 15);
         end else if (pick < 60) begin
            add_separator();
            add_text("IM");
            add_block_bytes(BufferDepth - 1);
         end else if (pick < 66) begin
            add_separator();
            add_text("MS");
            if ($urandom_range(2) == 0) add_short_length();
            else add_hex4(ms_length, $urandom_range(1));
            add_block_bytes(BufferDepth);
         end else if (pick < 72) begin
            add_separator();
            add_text("MS");
            other_length = 16'($urandom_range(16'hFFFF));
            if (other_length == ms_length) other_length = other_length ^ 16'h0001;
            if ($urandom_range(3) == 0) begin
               add_char("x");
               add_char(hex_char(other_length[11:8], 1'b1));
               add_char(hex_char(other_length[7:4], 1'b0));
               add_char(hex_char(other_length[3:0], 1'b1));
            end else begin
               add_hex4(other_length, $urandom_range(1));
            end
         end else if (pick < 86) begin
            repeat ($urandom_range(1, 6)) add_char(char_type'($urandom_range(255)));
         end else begin
            // Broken frames: cut short by a bad character, after one checksum digit,
            // or a lone letter.
            case ($urandom_range(2))
               0: begin
                  void'(add_random_tag());
                  repeat ($urandom_range(3)) add_char(numeric_char());
                  add_char(char_type'($urandom_range(1) ? "#" : random_letter()));
               end
               1: begin
                  void'(add_random_tag());
                  repeat ($urandom_range(3)) add_char(numeric_char());
                  add_char(":");
                  add_char(hex_char(4'($urandom_range(15)), $urandom_range(1)));
               end
               default: begin
                  add_char(random_letter());
               end
            endcase
         end
         send_outgoing();
      end

      // Drop valid, wait for the outstanding frame bytes, then let the pipeline settle.
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (DrainCycles) @(posedge clock);
      @(negedge clock);
      if (failures == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ tagged_frame_parser_crc8_unit.f @@
design/tfp_pkg.sv
design/tfp_frame_store.sv
design/tagged_frame_parser_crc8_unit.sv
tb/tfp_frame_checker.sv
tb/testbench.sv
